// ===== design/ktm_pkg.sv =====
package ktm_pkg;

  localparam int unsigned SINE_TABLE_ENTRIES = 1024;
  localparam int unsigned SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);

  localparam int unsigned PHASE_W = 32;
  localparam int unsigned SHIFT_W = 31;
  localparam int unsigned ENV_W = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RATE_W = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ENV_W-1:0] ENV_TARGET_OOK = 16'd23593;
  localparam logic [ENV_W-1:0] ENV_TARGET_FSK = 16'd18350;
  localparam logic [RATE_W-1:0] ENV_RATE_OOK = 12'd2621;
  localparam logic [RATE_W-1:0] ENV_RATE_FSK = 12'd1966;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_STEP  = 2'd0,
    REG_SHIFT_STEP = 2'd1,
    REG_MODE_FSK   = 2'd2,
    REG_PIXEL_STEP = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic load_item;
    logic upd_env;
    logic load_out;
  } dp_cmd_t;

  typedef logic signed [SAMPLE_W-1:0] sine_lut_t [SINE_TABLE_ENTRIES];

  // Quarter-wave folding and a Taylor series in Q30, terms up to x^9.
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k);
    logic [63:0] turns;
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic signed [63:0] sum;
    logic [63:0] amp;
    turns = (64'(k) << 32) / SINE_TABLE_ENTRIES;
    quad = turns[31:30];
    r = {34'd0, turns[29:0]};
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    sum = signed'(x);
    t = ((x * x2) >> 30) / 64'd6;
    sum = sum - signed'(t);
    t = ((t * x2) >> 30) / 64'd20;
    sum = sum + signed'(t);
    t = ((t * x2) >> 30) / 64'd42;
    sum = sum - signed'(t);
    t = ((t * x2) >> 30) / 64'd72;
    sum = sum + signed'(t);
    if (sum < 0) begin
      sum = 0;
    end
    amp = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (amp > 64'd32767) begin
      amp = 64'd32767;
    end
    return quad[1] ? -signed'(amp[SAMPLE_W-1:0]) : signed'(amp[SAMPLE_W-1:0]);
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int unsigned i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      lut[i] = sine_entry(i);
    end
    return lut;
  endfunction

endpackage

// ===== design/ktm_in_if.sv =====
interface ktm_in_if;
  logic valid;
  logic ready;
  logic keyed;

  modport source (output valid, output keyed, input ready);
  modport sink (input valid, input keyed, output ready);
endinterface

// ===== design/ktm_out_if.sv =====
interface ktm_out_if import ktm_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       next_pixel;

  modport source (output valid, output sample, output next_pixel, input ready);
  modport sink (input valid, input sample, input next_pixel, output ready);
endinterface

// ===== design/keyed_tone_modulator.sv =====
// An accepted beat passes through the phase update, then the envelope multiply alongside
// the sine ROM read, then the sample multiply, each registered; a new input beat is
// accepted only once the previous beat has been loaded into the output register.
// The output register lets the next input beat be accepted while a result waits; a stall
// on the output holds the following beat in the multiply cycle until the register frees.
// Reset clears the configuration registers, phase, envelope and pixel fraction to zero.
module keyed_tone_modulator import ktm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ktm_in_if.sink                in_i,
  ktm_out_if.source             out_o
);

  dp_cmd_t cmd;

  ktm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  ktm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .keyed_i      (in_i.keyed),
    .sample_o     (out_o.sample),
    .next_pixel_o (out_o.next_pixel)
  );

endmodule

// ===== design/ktm_ctrl.sv =====
module ktm_ctrl import ktm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ENV  = 3'b010,
    ST_MUL  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_ENV;
        end
      end
      ST_ENV: begin
        cmd_o.upd_env = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/ktm_dp.sv =====
module ktm_dp import ktm_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  dp_cmd_t                    cmd_i,
  input  logic                       keyed_i,
  output logic signed [SAMPLE_W-1:0] sample_o,
  output logic                       next_pixel_o
);

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  logic [PHASE_W-1:0] tone_step_q;
  logic [SHIFT_W-1:0] shift_step_q;
  logic               mode_fsk_q;
  logic [PHASE_W-1:0] pixel_step_q;

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [ENV_W-1:0]   env_q, env_d;
  logic [PHASE_W-1:0] pix_frac_q;
  logic [PHASE_W:0]   pix_sum;
  logic               key_q;
  logic               carry_q;
  logic [PHASE_W-1:0] step;

  logic signed [SAMPLE_W-1:0] sine_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       next_pixel_q;

  logic [ENV_W-1:0]   target;
  logic [RATE_W-1:0]  rate;
  logic signed [ENV_W:0]        diff;
  logic signed [ENV_W+RATE_W:0] env_prod;
  logic [ENV_W+RATE_W:0]        env_mag;
  logic [ENV_W+RATE_W:0]        env_q_rnd;
  logic [ENV_W-1:0]             env_delta;

  logic signed [ENV_W+SAMPLE_W:0] smp_prod;
  logic [ENV_W+SAMPLE_W:0]        smp_mag;
  logic [ENV_W+SAMPLE_W:0]        smp_rnd;
  logic [SAMPLE_W-1:0]            smp_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_step_q <= '0;
      shift_step_q <= '0;
      mode_fsk_q <= 1'b0;
      pixel_step_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TONE_STEP:  tone_step_q <= cfg_data_i[PHASE_W-1:0];
        REG_SHIFT_STEP: shift_step_q <= cfg_data_i[SHIFT_W-1:0];
        REG_MODE_FSK:   mode_fsk_q <= cfg_data_i[0];
        REG_PIXEL_STEP: pixel_step_q <= cfg_data_i[PHASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (!mode_fsk_q) begin
      step = tone_step_q;
    end else if (keyed_i) begin
      step = tone_step_q - {1'b0, shift_step_q};
    end else begin
      step = tone_step_q + {1'b0, shift_step_q};
    end
    phase_d = phase_q + step;
    pix_sum = {1'b0, pix_frac_q} + {1'b0, pixel_step_q};
  end

  always_comb begin
    if (mode_fsk_q) begin
      target = ENV_TARGET_FSK;
      rate = ENV_RATE_FSK;
    end else begin
      target = key_q ? ENV_TARGET_OOK : '0;
      rate = ENV_RATE_OOK;
    end
    diff = signed'({1'b0, target}) - signed'({1'b0, env_q});
    env_prod = diff * signed'({1'b0, rate});
    env_mag = env_prod[ENV_W+RATE_W] ? unsigned'(-env_prod) : unsigned'(env_prod);
    env_q_rnd = (env_mag + (ENV_W+RATE_W+1)'(1 << 15)) >> 16;
    env_delta = env_prod[ENV_W+RATE_W] ? -env_q_rnd[ENV_W-1:0] : env_q_rnd[ENV_W-1:0];
    env_d = env_q + env_delta;
  end

  always_comb begin
    smp_prod = signed'({1'b0, env_q}) * sine_q;
    smp_mag = smp_prod[ENV_W+SAMPLE_W] ? unsigned'(-smp_prod) : unsigned'(smp_prod);
    smp_rnd = (smp_mag + (ENV_W+SAMPLE_W+1)'(1 << 14)) >> 15;
    smp_val = smp_prod[ENV_W+SAMPLE_W] ? -smp_rnd[SAMPLE_W-1:0] : smp_rnd[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      env_q <= '0;
      pix_frac_q <= '0;
    end else begin
      if (cmd_i.load_item) begin
        phase_q <= phase_d;
        pix_frac_q <= pix_sum[PHASE_W-1:0];
      end
      if (cmd_i.upd_env) begin
        env_q <= env_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sine_q <= SINE_LUT[phase_q[PHASE_W-1 -: SINE_IDX_W]];
    if (cmd_i.load_item) begin
      key_q <= keyed_i;
      carry_q <= pix_sum[PHASE_W];
    end
    if (cmd_i.load_out) begin
      sample_q <= signed'(smp_val);
      next_pixel_q <= carry_q;
    end
  end

  assign sample_o = sample_q;
  assign next_pixel_o = next_pixel_q;

endmodule

// ===== dv/tb.sv =====
module tb;
  import ktm_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       next_pixel;
  } tone_beat_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_TICK,
    ROW_PINNED
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    cfg_reg_e              idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  key;
    tone_beat_t            want;
  } plan_row_t;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned PHASES        = 10;
  localparam int unsigned PHASE_TICKS   = 75;
  localparam int unsigned PLAN_ROWS     = 28;
  localparam tone_beat_t  SILENT        = '{16'sd0, 1'b0};
  localparam tone_beat_t  SILENT_CARRY  = '{16'sd0, 1'b1};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ktm_in_if  in_ch ();
  ktm_out_if out_ch ();

  keyed_tone_modulator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Shadow of the modulator: registers as written, then phase, envelope and pixel position.
  logic [PHASE_W-1:0] tone_q  = '0;
  logic [PHASE_W-1:0] shift_q = '0;
  logic               fsk_q   = 1'b0;
  logic [PHASE_W-1:0] pix_q   = '0;
  logic [PHASE_W-1:0] phase_q = '0;
  logic [ENV_W-1:0]   env_q   = '0;
  logic [PHASE_W-1:0] frac_q  = '0;

  logic signed [SAMPLE_W-1:0] sine_q15 [SINE_TABLE_ENTRIES];

  tone_beat_t  pending_tones [$];
  tone_beat_t  oldest;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_PINNED, REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_PINNED, REG_TONE_STEP,  32'h0000_0000, 1'b0, SILENT},
    '{ROW_WRITE,  REG_PIXEL_STEP, 32'hFFFF_FFFF, 1'b0, SILENT},
    '{ROW_PINNED, REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_PINNED, REG_TONE_STEP,  32'h0000_0000, 1'b0, SILENT_CARRY},
    '{ROW_WRITE,  REG_TONE_STEP,  32'h4000_0000, 1'b0, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b0, SILENT},
    '{ROW_WRITE,  REG_TONE_STEP,  32'hFFFF_FFFF, 1'b0, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b0, SILENT},
    '{ROW_WRITE,  REG_SHIFT_STEP, 32'hFFFF_FFFF, 1'b0, SILENT},
    '{ROW_WRITE,  REG_MODE_FSK,   32'hFFFF_FFFF, 1'b0, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b0, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_WRITE,  REG_TONE_STEP,  32'h0000_0000, 1'b0, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b0, SILENT},
    '{ROW_WRITE,  REG_PIXEL_STEP, 32'h0000_0000, 1'b0, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b0, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_WRITE,  REG_MODE_FSK,   32'h0000_0002, 1'b0, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b0, SILENT},
    '{ROW_TICK,   REG_TONE_STEP,  32'h0000_0000, 1'b1, SILENT}
  };

  function automatic longint half_round(input longint v, input int sh);
    longint mag;
    longint q;
    mag = (v < 0) ? -v : v;
    q = (mag + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -q : q;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] taylor_sine(input int unsigned k);
    logic [63:0]        turns;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic [63:0]        amp;
    logic signed [63:0] acc;
    int unsigned        n;
    turns = (64'(k) << 32) / SINE_TABLE_ENTRIES;
    r = turns & 64'h3FFF_FFFF;
    if (turns[30]) begin
      r = (64'd1 << 30) - r;
    end
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t = x;
    acc = $signed(x);
    for (n = 1; n <= 4; n++) begin
      t = ((t * x2) >> 30) / (64'(2 * n) * 64'(2 * n + 1));
      acc = n[0] ? acc - $signed(t) : acc + $signed(t);
    end
    if (acc < 0) begin
      acc = 0;
    end
    amp = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (amp > 64'd32767) begin
      amp = 64'd32767;
    end
    return turns[31] ? -$signed(amp[SAMPLE_W-1:0]) : $signed(amp[SAMPLE_W-1:0]);
  endfunction

  function automatic tone_beat_t next_tone(input logic key);
    logic [PHASE_W-1:0]    step;
    logic [PHASE_W:0]      frac_sum;
    longint                target;
    longint                rate;
    longint                env_next;
    longint                prod;
    logic [SINE_IDX_W-1:0] k;
    tone_beat_t            beat;
    if (fsk_q) begin
      step = key ? tone_q - shift_q : tone_q + shift_q;
      target = ENV_TARGET_FSK;
      rate = ENV_RATE_FSK;
    end else begin
      step = tone_q;
      target = key ? ENV_TARGET_OOK : 0;
      rate = ENV_RATE_OOK;
    end
    phase_q = phase_q + step;
    env_next = longint'(env_q) + half_round((target - longint'(env_q)) * rate, 16);
    env_q = env_next[ENV_W-1:0];
    k = phase_q[PHASE_W-1 -: SINE_IDX_W];
    prod = half_round(longint'(env_q) * longint'(sine_q15[k]), 15);
    beat.sample = prod[SAMPLE_W-1:0];
    frac_sum = {1'b0, frac_q} + {1'b0, pix_q};
    beat.next_pixel = frac_sum[PHASE_W];
    frac_q = frac_sum[PHASE_W-1:0];
    return beat;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_word();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // Registers are only written once every outstanding sample has come back.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_TONE_STEP:  tone_q = data;
      REG_SHIFT_STEP: shift_q = {1'b0, data[SHIFT_W-1:0]};
      REG_MODE_FSK:   fsk_q = data[0];
      REG_PIXEL_STEP: pix_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_tick(input logic key, input bit pinned, input tone_beat_t want);
    tone_beat_t beat;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.keyed <= key;
    do @(posedge clk_i); while (!in_ch.ready);
    beat = next_tone(key);
    pending_tones.push_back(pinned ? want : beat);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 9);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_tones.size() == 0) begin
        flag_mismatch("sample beat arrived with nothing outstanding");
      end else begin
        oldest = pending_tones.pop_front();
        if (out_ch.sample !== oldest.sample) begin
          flag_mismatch($sformatf("sample %0d, expected %0d", out_ch.sample, oldest.sample));
        end
        if (out_ch.next_pixel !== oldest.next_pixel) begin
          flag_mismatch($sformatf("next_pixel %0b, expected %0b",
                                  out_ch.next_pixel, oldest.next_pixel));
        end
      end
    end
  end

  initial begin
    int unsigned p;
    int unsigned sent;
    int unsigned run;
    int unsigned i;
    logic        key;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_TONE_STEP;
    cfg_data_i   = '0;
    in_ch.valid  = 1'b0;
    in_ch.keyed  = 1'b0;
    for (i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      sine_q15[i] = taylor_sine(i);
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_tick(plan[i].key, plan[i].kind == ROW_PINNED, plan[i].want);
      end
    end

    // Raster pixels are runs of equal key bits, with the odd isolated bit thrown in.
    for (p = 0; p < PHASES; p++) begin
      calm = (p == 4);
      write_reg(REG_TONE_STEP, (p == 0) ? '1 : (p == 1) ? '0 : pick_word());
      write_reg(REG_SHIFT_STEP, (p == 0) ? '1 : (p == 1) ? '0 : pick_word());
      write_reg(REG_MODE_FSK, (p == 0) ? 32'd1 : (p == 1) ? 32'd0 : $urandom);
      write_reg(REG_PIXEL_STEP, (p == 0) ? '1 : (p == 1) ? '0 : pick_word());
      sent = 0;
      while (sent < PHASE_TICKS) begin
        if ($urandom_range(9) == 0) begin
          send_tick(1'($urandom_range(1)), 1'b0, SILENT);
          sent++;
        end else begin
          run = $urandom_range(12, 1);
          key = 1'($urandom_range(1));
          for (i = 0; i < run && sent < PHASE_TICKS; i++) begin
            send_tick(key, 1'b0, SILENT);
            sent++;
          end
        end
      end
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES * 2) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
